// ----- rtl/core/lhpt_pkg.sv -----
// Shared types, link codes and size defaults for the link handshake packet transfer block.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
`default_nettype none
package lhpt_pkg;

    localparam int QUEUE_SLOTS_DEF  = 4;
    localparam int PACKET_BYTES_DEF = 256;
    localparam int CHUNK_BYTES_DEF  = 16;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_LINK = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;
    localparam logic [1:0] OP_POP  = 2'd3;

    localparam logic [7:0] CODE_START   = 8'h01;
    localparam logic [7:0] CODE_HELLO   = 8'h02;
    localparam logic [7:0] CODE_CONFIRM = 8'h03;
    localparam logic [7:0] CODE_REQUEST = 8'h04;
    localparam logic [7:0] CODE_ACCEPT  = 8'h05;
    localparam logic [7:0] CODE_FULL    = 8'h06;
    localparam logic [7:0] CODE_ACK     = 8'h07;

    localparam logic CFG_MASTER_MODE = 1'b0;
    localparam logic CFG_WAIT_TICKS  = 1'b1;
    localparam logic [15:0] WAIT_TICKS_RESET = 16'd1000;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] link_byte;
        logic       link_tx_ready;
        logic [7:0] host_byte;
        logic       host_last;
    } t_in;

    typedef struct packed {
        logic        link_tx_valid;
        logic [7:0]  link_tx_byte;
        logic        link_rx_taken;
        logic        host_rx_valid;
        logic [7:0]  host_rx_byte;
        logic        host_rx_last;
        logic [15:0] host_rx_length;
        logic        load_accepted;
        logic        send_pending;
        logic        link_connected;
        logic [2:0]  queue_count;
    } t_out;

    // A classified request as it travels from the front queue to the engine.
    typedef struct packed {
        logic       is_proto;
        logic       have;
        logic       is_load;
        logic       is_pop;
        logic [7:0] link_byte;
        logic       link_tx_ready;
        logic [7:0] host_byte;
        logic       host_last;
    } t_cmd;

    typedef struct packed {
        logic        master_mode;
        logic [15:0] connect_wait_ticks;
    } t_cfg;

endpackage
`default_nettype wire

// ----- rtl/core/link_handshake_packet_transfer.sv -----
// Top level of the link handshake packet transfer block: configuration registers,
// front request queue and protocol engine. Depends on lhpt_pkg, lhpt_front, lhpt_engine.
`default_nettype none
// Each request (a tick, an offered link byte, a host load or a host pop) yields exactly
// one result. One request per cycle is sustained while the output is not held back; a
// request is registered in the two-entry front queue, and its result in the result
// register, which holds it until the output is ready. The engine reads its packet
// buffers ahead, at the addresses of the state it is about to enter, so a pop or a data
// send finds its byte ready. The user must write the master or slave role and the connect
// timeout through the configuration port only while no request is in flight; the block
// itself does not enforce it. The receive store holds QUEUE_SLOTS packets of PACKET_BYTES
// each; there is no clearing pass after reset, since only written bytes are ever read.
module link_handshake_packet_transfer #(
    parameter int QUEUE_SLOTS  = lhpt_pkg::QUEUE_SLOTS_DEF,
    parameter int PACKET_BYTES = lhpt_pkg::PACKET_BYTES_DEF,
    parameter int CHUNK_BYTES  = lhpt_pkg::CHUNK_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lhpt_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output lhpt_pkg::t_out     o_out_data,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic          i_cfg_index,
    input  wire logic [15:0]   i_cfg_data
);

    lhpt_pkg::t_cfg r_cfg;
    lhpt_pkg::t_cmd cmd;
    logic           cmd_valid;
    logic           cmd_take;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.master_mode        <= 1'b0;
            r_cfg.connect_wait_ticks <= lhpt_pkg::WAIT_TICKS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lhpt_pkg::CFG_MASTER_MODE: begin
                    r_cfg.master_mode <= i_cfg_data[0];
                end
                lhpt_pkg::CFG_WAIT_TICKS: begin
                    r_cfg.connect_wait_ticks <= i_cfg_data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    lhpt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in_data),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    lhpt_engine #(
        .QUEUE_SLOTS  (QUEUE_SLOTS),
        .PACKET_BYTES (PACKET_BYTES),
        .CHUNK_BYTES  (CHUNK_BYTES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule
`default_nettype wire

// ----- rtl/core/lhpt_front.sv -----
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on lhpt_pkg.
`default_nettype none
module lhpt_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lhpt_pkg::t_in i_in,
    output logic               o_cmd_valid,
    output lhpt_pkg::t_cmd     o_cmd,
    input  wire logic          i_cmd_take
);

    lhpt_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    lhpt_pkg::t_cmd n_cmd;
    logic           push;

    always_comb begin
        n_cmd.is_proto      = (i_in.operation == lhpt_pkg::OP_TICK) ||
                              (i_in.operation == lhpt_pkg::OP_LINK);
        n_cmd.have          = (i_in.operation == lhpt_pkg::OP_LINK);
        n_cmd.is_load       = (i_in.operation == lhpt_pkg::OP_LOAD);
        n_cmd.is_pop        = (i_in.operation == lhpt_pkg::OP_POP);
        n_cmd.link_byte     = i_in.link_byte;
        n_cmd.link_tx_ready = i_in.link_tx_ready;
        n_cmd.host_byte     = i_in.host_byte;
        n_cmd.host_last     = i_in.host_last;
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign push        = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_take);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/lhpt_engine.sv -----
// Back end: protocol state machine, tx packet buffer, rx packet ring queue and result register.
// Depends on lhpt_pkg.
`default_nettype none
module lhpt_engine #(
    parameter int QUEUE_SLOTS  = lhpt_pkg::QUEUE_SLOTS_DEF,
    parameter int PACKET_BYTES = lhpt_pkg::PACKET_BYTES_DEF,
    parameter int CHUNK_BYTES  = lhpt_pkg::CHUNK_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lhpt_pkg::t_cfg i_cfg,
    input  wire logic           i_cmd_valid,
    input  wire lhpt_pkg::t_cmd i_cmd,
    output logic                o_cmd_take,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output lhpt_pkg::t_out      o_out
);

    localparam int PIW = $clog2(PACKET_BYTES);
    localparam int TLW = $clog2(PACKET_BYTES + 1);
    localparam int SW  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int FW  = $clog2(QUEUE_SLOTS + 1);
    localparam int RAW = $clog2(QUEUE_SLOTS * PACKET_BYTES);
    localparam int CW  = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

    localparam logic [4:0] ST_INIT           = 5'd0;
    localparam logic [4:0] ST_M_SEND_START   = 5'd1;
    localparam logic [4:0] ST_M_WAIT_HELLO   = 5'd2;
    localparam logic [4:0] ST_M_SEND_CONFIRM = 5'd3;
    localparam logic [4:0] ST_S_WAIT_START   = 5'd4;
    localparam logic [4:0] ST_S_SEND_HELLO   = 5'd5;
    localparam logic [4:0] ST_S_WAIT_CONFIRM = 5'd6;
    localparam logic [4:0] ST_IDLE           = 5'd7;
    localparam logic [4:0] ST_SEND_REQ       = 5'd8;
    localparam logic [4:0] ST_SEND_FULL      = 5'd9;
    localparam logic [4:0] ST_SEND_ACCEPT    = 5'd10;
    localparam logic [4:0] ST_WAIT_RESP      = 5'd11;
    localparam logic [4:0] ST_SEND_LEN       = 5'd12;
    localparam logic [4:0] ST_SEND_DATA      = 5'd13;
    localparam logic [4:0] ST_WAIT_ACK       = 5'd14;
    localparam logic [4:0] ST_SEND_DONE      = 5'd15;
    localparam logic [4:0] ST_RECV_LEN       = 5'd16;
    localparam logic [4:0] ST_RECV_DATA      = 5'd17;
    localparam logic [4:0] ST_SEND_ACK       = 5'd18;
    localparam logic [4:0] ST_RECV_DONE      = 5'd19;
    localparam logic [4:0] ST_ABORT          = 5'd20;

    logic [4:0]     r_state,   n_state;
    logic [TLW-1:0] r_tx_len,  n_tx_len;
    logic           r_pend,    n_pend;
    logic [SW-1:0]  r_wslot,   n_wslot;
    logic [SW-1:0]  r_rslot,   n_rslot;
    logic [FW-1:0]  r_fill,    n_fill;
    logic [PIW-1:0] r_pop_idx, n_pop_idx;
    logic [15:0]    r_cur_len, n_cur_len;
    logic [15:0]    r_bidx,    n_bidx;
    logic [CW-1:0]  r_chunk,   n_chunk;
    logic           r_phase,   n_phase;
    logic [15:0]    r_wait,    n_wait;
    logic           r_conn,    n_conn;

    logic [TLW-1:0] r_len_store [QUEUE_SLOTS];
    logic [7:0]     r_tx_mem    [PACKET_BYTES];
    logic [7:0]     r_rx_mem    [QUEUE_SLOTS * PACKET_BYTES];

    logic [7:0]     r_tx_rd;
    logic [7:0]     r_rx_rd;
    logic           r_rx_byp;
    logic [7:0]     r_rx_byp_d;
    logic [7:0]     rx_rd;

    logic           r_out_valid;
    lhpt_pkg::t_out r_out, n_out;

    logic           go;
    logic           tx_we;
    logic           rx_we;
    logic           len_we;
    logic [RAW-1:0] rx_wa;
    logic [RAW-1:0] rx_ra;
    logic [PIW-1:0] tx_ra;
    logic [15:0]    tx_len16;
    logic [16:0]    pop_next;
    logic [TLW-1:0] pop_len;
    logic           pop_last;
    logic           chunk_end;
    logic [7:0]     b;

    assign go          = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_cmd_take  = go;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign b         = i_cmd.link_byte;
    assign tx_len16  = 16'(r_tx_len);
    assign rx_rd     = r_rx_byp ? r_rx_byp_d : r_rx_rd;
    assign rx_wa     = RAW'(r_wslot) * RAW'(PACKET_BYTES) + RAW'(r_bidx);
    assign rx_ra     = RAW'(n_rslot) * RAW'(PACKET_BYTES) + RAW'(n_pop_idx);
    assign tx_ra     = PIW'(n_bidx);
    assign pop_len   = r_len_store[r_rslot];
    assign pop_next  = 17'(r_pop_idx) + 17'd1;
    assign pop_last  = (pop_next >= 17'(pop_len));
    assign chunk_end = (r_chunk == CW'(CHUNK_BYTES - 1));

    always_comb begin
        n_state   = r_state;
        n_tx_len  = r_tx_len;
        n_pend    = r_pend;
        n_wslot   = r_wslot;
        n_rslot   = r_rslot;
        n_fill    = r_fill;
        n_pop_idx = r_pop_idx;
        n_cur_len = r_cur_len;
        n_bidx    = r_bidx;
        n_chunk   = r_chunk;
        n_phase   = r_phase;
        n_wait    = r_wait;
        n_conn    = r_conn;
        n_out     = '0;
        tx_we     = 1'b0;
        rx_we     = 1'b0;
        len_we    = 1'b0;
        if (go && i_cmd.is_proto) begin
            case (r_state)
                ST_INIT: begin
                    n_tx_len  = '0;
                    n_pend    = 1'b0;
                    n_wslot   = '0;
                    n_rslot   = '0;
                    n_fill    = '0;
                    n_pop_idx = '0;
                    n_cur_len = '0;
                    n_bidx    = '0;
                    n_chunk   = '0;
                    n_phase   = 1'b0;
                    n_wait    = '0;
                    n_conn    = 1'b0;
                    n_out.link_rx_taken = i_cmd.have;
                    n_state = i_cfg.master_mode ? ST_M_SEND_START : ST_S_WAIT_START;
                end
                ST_M_SEND_START: begin
                    // Stale link bytes are flushed before START goes out.
                    if (i_cmd.have) begin
                        n_out.link_rx_taken = 1'b1;
                    end else if (i_cmd.link_tx_ready) begin
                        n_out.link_tx_valid = 1'b1;
                        n_out.link_tx_byte  = lhpt_pkg::CODE_START;
                        n_state = ST_M_WAIT_HELLO;
                    end
                    n_wait = '0;
                end
                ST_M_WAIT_HELLO: begin
                    if (i_cmd.have) begin
                        n_out.link_rx_taken = 1'b1;
                        n_state = (b == lhpt_pkg::CODE_HELLO) ? ST_M_SEND_CONFIRM
                                                              : ST_M_SEND_START;
                        n_wait = '0;
                    end else if (r_wait >= i_cfg.connect_wait_ticks) begin
                        n_wait  = '0;
                        n_state = ST_M_SEND_START;
                    end else begin
                        n_wait = r_wait + 16'd1;
                    end
                end
                ST_M_SEND_CONFIRM: begin
                    if (i_cmd.link_tx_ready) begin
                        n_out.link_tx_valid = 1'b1;
                        n_out.link_tx_byte  = lhpt_pkg::CODE_CONFIRM;
                        n_conn  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
                ST_S_WAIT_START: begin
                    if (i_cmd.have) begin
                        n_out.link_rx_taken = 1'b1;
                        if (b == lhpt_pkg::CODE_START) begin
                            n_state = ST_S_SEND_HELLO;
                        end
                    end
                end
                ST_S_SEND_HELLO: begin
                    if (i_cmd.link_tx_ready) begin
                        n_out.link_tx_valid = 1'b1;
                        n_out.link_tx_byte  = lhpt_pkg::CODE_HELLO;
                        n_state = ST_S_WAIT_CONFIRM;
                    end
                end
                ST_S_WAIT_CONFIRM: begin
                    if (i_cmd.have) begin
                        n_out.link_rx_taken = 1'b1;
                        if (b == lhpt_pkg::CODE_CONFIRM) begin
                            n_conn  = 1'b1;
                            n_state = ST_IDLE;
                        end else begin
                            n_state = ST_S_WAIT_START;
                        end
                    end
                end
                ST_IDLE: begin
                    if (i_cmd.have) begin
                        n_out.link_rx_taken = 1'b1;
                        if (b == lhpt_pkg::CODE_REQUEST) begin
                            if (i_cfg.master_mode && r_pend) begin
                                n_state = ST_SEND_REQ;
                            end else begin
                                n_state = (r_fill >= FW'(QUEUE_SLOTS)) ? ST_SEND_FULL
                                                                       : ST_SEND_ACCEPT;
                            end
                        end else if (b == lhpt_pkg::CODE_START) begin
                            n_state = ST_INIT;
                        end
                    end else if (r_pend) begin
                        n_state = ST_SEND_REQ;
                    end
                end
                ST_SEND_REQ: begin
                    if (i_cmd.link_tx_ready) begin
                        n_out.link_tx_valid = 1'b1;
                        n_out.link_tx_byte  = lhpt_pkg::CODE_REQUEST;
                        n_state = ST_WAIT_RESP;
                    end
                end
                ST_SEND_FULL: begin
                    if (i_cmd.link_tx_ready) begin
                        n_out.link_tx_valid = 1'b1;
                        n_out.link_tx_byte  = lhpt_pkg::CODE_FULL;
                        n_state = ST_IDLE;
                    end
                end
                ST_SEND_ACCEPT: begin
                    if (i_cmd.link_tx_ready) begin
                        n_out.link_tx_valid = 1'b1;
                        n_out.link_tx_byte  = lhpt_pkg::CODE_ACCEPT;
                        n_phase = 1'b0;
                        n_state = ST_RECV_LEN;
                    end
                end
                ST_WAIT_RESP: begin
                    if (i_cmd.have) begin
                        n_out.link_rx_taken = 1'b1;
                        if (b == lhpt_pkg::CODE_REQUEST) begin
                            if (!i_cfg.master_mode) begin
                                n_state = (r_fill >= FW'(QUEUE_SLOTS)) ? ST_SEND_FULL
                                                                       : ST_SEND_ACCEPT;
                            end
                        end else if (b == lhpt_pkg::CODE_ACCEPT) begin
                            n_phase = 1'b0;
                            n_state = ST_SEND_LEN;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
                ST_SEND_LEN: begin
                    if (i_cmd.link_tx_ready) begin
                        n_out.link_tx_valid = 1'b1;
                        if (!r_phase) begin
                            n_out.link_tx_byte = tx_len16[7:0];
                            n_phase = 1'b1;
                        end else begin
                            n_out.link_tx_byte = tx_len16[15:8];
                            n_phase = 1'b0;
                            n_bidx  = '0;
                            n_chunk = '0;
                            n_state = ST_SEND_DATA;
                        end
                    end
                end
                ST_SEND_DATA: begin
                    if (r_bidx >= tx_len16) begin
                        n_state = ST_WAIT_ACK;
                    end else if (i_cmd.link_tx_ready) begin
                        n_out.link_tx_valid = 1'b1;
                        n_out.link_tx_byte  = r_tx_rd;
                        n_bidx  = r_bidx + 16'd1;
                        n_chunk = chunk_end ? '0 : r_chunk + CW'(1);
                        if ((n_bidx >= tx_len16) || chunk_end) begin
                            n_state = ST_WAIT_ACK;
                        end
                    end
                end
                ST_WAIT_ACK: begin
                    if (i_cmd.have) begin
                        n_out.link_rx_taken = 1'b1;
                        if (b == lhpt_pkg::CODE_ACK) begin
                            n_state = (r_bidx < tx_len16) ? ST_SEND_DATA : ST_SEND_DONE;
                        end else begin
                            n_state = ST_ABORT;
                        end
                    end
                end
                ST_SEND_DONE: begin
                    n_pend   = 1'b0;
                    n_tx_len = '0;
                    n_state  = ST_IDLE;
                end
                ST_RECV_LEN: begin
                    if (i_cmd.have) begin
                        n_out.link_rx_taken = 1'b1;
                        if (!r_phase) begin
                            n_cur_len = {8'd0, b};
                            n_phase   = 1'b1;
                        end else begin
                            n_cur_len = {r_cur_len[15:8] | b, r_cur_len[7:0]};
                            n_phase   = 1'b0;
                            n_bidx    = '0;
                            n_chunk   = '0;
                            n_state   = ST_RECV_DATA;
                        end
                    end
                end
                ST_RECV_DATA: begin
                    if (r_bidx >= r_cur_len) begin
                        n_state = ST_SEND_ACK;
                    end else if (i_cmd.have) begin
                        n_out.link_rx_taken = 1'b1;
                        // Bytes past the slot size are consumed and dropped.
                        rx_we   = (r_bidx < 16'(PACKET_BYTES));
                        n_bidx  = r_bidx + 16'd1;
                        n_chunk = chunk_end ? '0 : r_chunk + CW'(1);
                        if ((n_bidx >= r_cur_len) || chunk_end) begin
                            n_state = ST_SEND_ACK;
                        end
                    end
                end
                ST_SEND_ACK: begin
                    if (i_cmd.link_tx_ready) begin
                        n_out.link_tx_valid = 1'b1;
                        n_out.link_tx_byte  = lhpt_pkg::CODE_ACK;
                        n_state = (r_bidx >= r_cur_len) ? ST_RECV_DONE : ST_RECV_DATA;
                    end
                end
                ST_RECV_DONE: begin
                    // With the queue full the packet is dropped.
                    if (r_fill < FW'(QUEUE_SLOTS)) begin
                        len_we  = 1'b1;
                        n_wslot = (r_wslot == SW'(QUEUE_SLOTS - 1)) ? '0 : r_wslot + SW'(1);
                        n_fill  = r_fill + FW'(1);
                    end
                    n_state = ST_IDLE;
                end
                ST_ABORT: begin
                    n_state = ST_IDLE;
                end
                default: begin
                    n_state = ST_INIT;
                end
            endcase
        end else if (go && i_cmd.is_load) begin
            if (!r_pend) begin
                if (r_tx_len < TLW'(PACKET_BYTES)) begin
                    tx_we    = 1'b1;
                    n_tx_len = r_tx_len + TLW'(1);
                end
                if (i_cmd.host_last) begin
                    n_pend = 1'b1;
                end
                n_out.load_accepted = 1'b1;
            end
        end else if (go && i_cmd.is_pop) begin
            if (r_fill != '0) begin
                n_out.host_rx_valid  = 1'b1;
                n_out.host_rx_byte   = (17'(r_pop_idx) < 17'(pop_len)) ? rx_rd : 8'd0;
                n_out.host_rx_last   = pop_last;
                n_out.host_rx_length = 16'(pop_len);
                if (pop_last) begin
                    n_pop_idx = '0;
                    n_rslot   = (r_rslot == SW'(QUEUE_SLOTS - 1)) ? '0 : r_rslot + SW'(1);
                    n_fill    = r_fill - FW'(1);
                end else begin
                    n_pop_idx = r_pop_idx + PIW'(1);
                end
            end
        end
        n_out.send_pending   = n_pend;
        n_out.link_connected = n_conn;
        n_out.queue_count    = 3'(n_fill);
    end

    // The buffers are read every cycle at the address the next request will use.
    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            r_tx_mem[PIW'(r_tx_len)] <= i_cmd.host_byte;
        end
        r_tx_rd <= r_tx_mem[tx_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            r_rx_mem[rx_wa] <= b;
        end
        r_rx_rd    <= r_rx_mem[rx_ra];
        r_rx_byp   <= rx_we && (rx_wa == rx_ra);
        r_rx_byp_d <= b;
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len_store[r_wslot] <= (r_cur_len > 16'(PACKET_BYTES)) ? TLW'(PACKET_BYTES)
                                                                    : TLW'(r_cur_len);
        end
        if (go) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_tx_len    <= '0;
            r_pend      <= 1'b0;
            r_wslot     <= '0;
            r_rslot     <= '0;
            r_fill      <= '0;
            r_pop_idx   <= '0;
            r_cur_len   <= '0;
            r_bidx      <= '0;
            r_chunk     <= '0;
            r_phase     <= 1'b0;
            r_wait      <= '0;
            r_conn      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tx_len    <= n_tx_len;
            r_pend      <= n_pend;
            r_wslot     <= n_wslot;
            r_rslot     <= n_rslot;
            r_fill      <= n_fill;
            r_pop_idx   <= n_pop_idx;
            r_cur_len   <= n_cur_len;
            r_bidx      <= n_bidx;
            r_chunk     <= n_chunk;
            r_phase     <= n_phase;
            r_wait      <= n_wait;
            r_conn      <= n_conn;
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(QUEUE_SLOTS))
        else $error("rx queue fill exceeds slot count");

    a_send_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEND_DATA) || (r_state == ST_SEND_LEN) |-> r_pend)
        else $error("data sent without a pending packet");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && i_cmd.is_pop && (r_fill == '0) |=> !r_out.host_rx_valid)
        else $error("pop on empty queue returned a byte");

    a_tx_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_len <= TLW'(PACKET_BYTES))
        else $error("tx length past buffer size");

endmodule
`default_nettype wire
